FILE: design/assert_macros.svh
// Assertion macros used by the design files (included by mp3_vbr_header_parser).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: design/mvhp_pkg.sv
// Types and constants for the MP3 VBR header parser.
package mvhp_pkg;

   localparam logic [31:0] TAG_XING = 32'h5869_6E67;
   localparam logic [31:0] TAG_INFO = 32'h496E_666F;
   localparam logic [31:0] TAG_VBRI = 32'h5642_5249;

   localparam logic [7:0] SIDE_M1_MONO   = 8'd21;  // 4 + 17
   localparam logic [7:0] SIDE_M1_STEREO = 8'd36;  // 4 + 32
   localparam logic [7:0] SIDE_M2_MONO   = 8'd13;  // 4 + 9
   localparam logic [7:0] SIDE_M2_STEREO = 8'd21;  // 4 + 17

   localparam logic [7:0] VBRI_AT       = 8'd36;
   localparam logic [7:0] VBRI_TAG_END  = 8'd39;
   localparam logic [7:0] VBRI_BYTES_AT = 8'd49;
   localparam logic [7:0] VBRI_FRMS_AT  = 8'd53;
   localparam logic [7:0] VBRI_LAST_MIN = 8'd61;  // frame length 62
   localparam logic [7:0] SHORT_LAST    = 8'd39;  // frame length 40
   localparam logic [7:0] POS_MAX       = 8'd255;

   localparam int unsigned TOC_LEN = 100;
   localparam int unsigned TOC_AW  = $clog2(TOC_LEN);

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_XING = 2'd1;
   localparam logic [1:0] KIND_VBRI = 2'd2;

   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_TOC  = 1'b1;

   // flag bit order: frames, bytes, TOC
   localparam int unsigned FLAG_FRAMES = 0;
   localparam int unsigned FLAG_BYTES  = 1;
   localparam int unsigned FLAG_TOC    = 2;

   typedef struct packed {
      logic [1:0]  header_kind;
      logic        frames_valid;
      logic [31:0] frame_count;
      logic        bytes_valid;
      logic [31:0] byte_count;
      logic        toc_valid;
      logic [7:0]  toc_entry;
   } rsp_type;

endpackage

FILE: design/mp3_vbr_header_parser.sv
// A summary or TOC read word passes through the read stage and then the output register.
// Throughput: one word per cycle while req_ready is high; a TOC read is one port of the TOC memory.
// Two result words can be held (read stage and output register) before req_ready drops.
// Synchronous active-high reset clears the frame position, the parse state and
// the result pipeline; the TOC memory holds garbage until a frame writes it.
`include "assert_macros.svh"

module mp3_vbr_header_parser import mvhp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_action,
   input  logic [7:0]        req_frame_byte,
   input  logic              req_is_mono,
   input  logic              req_last_byte,
   input  logic [TOC_AW-1:0] req_toc_index,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_header_kind,
   output logic              rsp_frames_valid,
   output logic [31:0]       rsp_frame_count,
   output logic              rsp_bytes_valid,
   output logic [31:0]       rsp_byte_count,
   output logic              rsp_toc_valid,
   output logic [7:0]        rsp_toc_entry
);

   // parse state
   logic [7:0]  pos_ff, pos_in;
   logic        mpeg1_ff, mpeg1_in;
   logic [31:0] win_ff, win_in;
   logic [2:0]  flags_ff, flags_in;
   logic [31:0] frames_ff, frames_in;
   logic [31:0] bytes_ff, bytes_in;
   logic [2:0]  marks_ff, marks_in;
   logic [1:0]  kind_ff, kind_in;
   logic        toc_rdy_ff, toc_rdy_in;

   // result pipeline
   logic        s1_valid_ff, s1_valid_in;
   rsp_type     s1_res_ff, s1_res_in;
   logic        s1_toc_ok_ff, s1_toc_ok_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_res_ff, out_res_in;

   logic [7:0]  toc_mem [TOC_LEN];
   logic [7:0]  rd_data_ff;

   logic        accept, is_byte, is_read, new_frame, s1_advance, produce;
   logic [7:0]  off, tstart, toc_off;
   logic        toc_we, toc_ok;
   logic [TOC_AW-1:0] rd_addr;
   rsp_type     sum_res;

   assign s1_advance = !out_valid_ff || rsp_ready;
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign accept     = req_valid && req_ready;
   assign is_byte    = accept && (req_action == ACT_BYTE);
   assign is_read    = accept && (req_action == ACT_TOC);
   assign new_frame  = (pos_ff == 8'd0);
   assign produce    = is_read || (is_byte && req_last_byte);

   always_comb begin
      logic [1:0]  k;
      logic [2:0]  fl;
      logic [2:0]  mk;
      logic [31:0] fr;
      logic [31:0] by;
      logic        m1;
      k  = new_frame ? KIND_NONE : kind_ff;
      fl = new_frame ? 3'd0 : flags_ff;
      mk = new_frame ? 3'd0 : marks_ff;
      fr = new_frame ? 32'd0 : frames_ff;
      by = new_frame ? 32'd0 : bytes_ff;
      m1 = new_frame ? 1'b0 : mpeg1_ff;

      win_in = {(new_frame ? 24'd0 : win_ff[23:0]), req_frame_byte};
      if (pos_ff == 8'd1) begin
         m1 = (req_frame_byte[4:3] == 2'b11);
      end

      if (m1) begin
         off = req_is_mono ? SIDE_M1_MONO : SIDE_M1_STEREO;
      end else begin
         off = req_is_mono ? SIDE_M2_MONO : SIDE_M2_STEREO;
      end

      if (pos_ff == off + 8'd3 && (win_in == TAG_XING || win_in == TAG_INFO)) begin
         k = KIND_XING;
      end
      if (pos_ff == off + 8'd7 && k == KIND_XING) begin
         fl = win_in[2:0];
      end

      tstart  = off + 8'd8 + (fl[FLAG_FRAMES] ? 8'd4 : 8'd0)
                + (fl[FLAG_BYTES] ? 8'd4 : 8'd0);
      toc_off = pos_ff - tstart;
      toc_we  = 1'b0;

      if (k == KIND_XING && pos_ff > off + 8'd7) begin
         if (fl[FLAG_FRAMES] && pos_ff == off + 8'd11) begin
            fr = win_in;
            mk[FLAG_FRAMES] = 1'b1;
         end
         if (fl[FLAG_BYTES] && pos_ff == tstart - (fl[FLAG_BYTES] ? 8'd1 : 8'd0)) begin
            by = win_in;
            mk[FLAG_BYTES] = 1'b1;
         end
         if (fl[FLAG_TOC] && pos_ff >= tstart && toc_off < 8'(TOC_LEN)) begin
            toc_we = is_byte;
            if (toc_off == 8'(TOC_LEN - 1)) begin
               mk[FLAG_TOC] = 1'b1;
            end
         end
      end

      if (off == VBRI_AT && pos_ff == VBRI_TAG_END && k == KIND_NONE
          && win_in == TAG_VBRI) begin
         k = KIND_VBRI;
      end
      if (k == KIND_VBRI) begin
         if (pos_ff == VBRI_BYTES_AT) begin
            by = win_in;
         end
         if (pos_ff == VBRI_FRMS_AT) begin
            fr = win_in;
         end
      end

      kind_in   = k;
      flags_in  = fl;
      marks_in  = mk;
      frames_in = fr;
      bytes_in  = by;
      mpeg1_in  = m1;

      if (req_last_byte) begin
         pos_in = 8'd0;
      end else if (pos_ff != POS_MAX) begin
         pos_in = pos_ff + 8'd1;
      end else begin
         pos_in = pos_ff;
      end

      // summary on the last byte
      sum_res = '0;
      if (pos_ff >= SHORT_LAST) begin
         if (k == KIND_XING && pos_ff >= off + 8'd7) begin
            sum_res.header_kind  = KIND_XING;
            sum_res.frames_valid = mk[FLAG_FRAMES];
            sum_res.frame_count  = mk[FLAG_FRAMES] ? fr : 32'd0;
            sum_res.bytes_valid  = mk[FLAG_BYTES];
            sum_res.byte_count   = mk[FLAG_BYTES] ? by : 32'd0;
            sum_res.toc_valid    = mk[FLAG_TOC];
         end else if (k == KIND_VBRI && pos_ff >= VBRI_LAST_MIN) begin
            sum_res.header_kind  = KIND_VBRI;
            sum_res.frames_valid = 1'b1;
            sum_res.frame_count  = fr;
            sum_res.bytes_valid  = 1'b1;
            sum_res.byte_count   = by;
         end
      end

      if (req_last_byte) begin
         toc_rdy_in = sum_res.toc_valid;
      end else if (new_frame) begin
         toc_rdy_in = 1'b0;
      end else begin
         toc_rdy_in = toc_rdy_ff;
      end
   end

   assign toc_ok  = toc_rdy_ff && (req_toc_index < TOC_AW'(TOC_LEN));
   assign rd_addr = toc_ok ? req_toc_index : '0;

   always_ff @(posedge clock) begin
      if (toc_we) begin
         toc_mem[toc_off[TOC_AW-1:0]] <= req_frame_byte;
      end
      if (is_read) begin
         rd_data_ff <= toc_mem[rd_addr];
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_res_in    = s1_res_ff;
      s1_toc_ok_in = s1_toc_ok_ff;
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (s1_advance) begin
         out_valid_in = s1_valid_ff;
         out_res_in   = s1_res_ff;
         out_res_in.toc_entry = s1_toc_ok_ff ? rd_data_ff : 8'd0;
         s1_valid_in  = 1'b0;
      end
      if (produce) begin
         s1_valid_in  = 1'b1;
         s1_res_in    = is_read ? '0 : sum_res;
         s1_toc_ok_in = is_read && toc_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 8'd0;
         mpeg1_ff     <= 1'b0;
         flags_ff     <= 3'd0;
         marks_ff     <= 3'd0;
         kind_ff      <= KIND_NONE;
         toc_rdy_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s1_toc_ok_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (is_byte) begin
            pos_ff     <= pos_in;
            mpeg1_ff   <= mpeg1_in;
            flags_ff   <= flags_in;
            marks_ff   <= marks_in;
            kind_ff    <= kind_in;
            toc_rdy_ff <= toc_rdy_in;
         end
         s1_valid_ff  <= s1_valid_in;
         s1_toc_ok_ff <= s1_toc_ok_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (is_byte) begin
         win_ff    <= win_in;
         frames_ff <= frames_in;
         bytes_ff  <= bytes_in;
      end
      s1_res_ff  <= s1_res_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_header_kind  = out_res_ff.header_kind;
   assign rsp_frames_valid = out_res_ff.frames_valid;
   assign rsp_frame_count  = out_res_ff.frame_count;
   assign rsp_bytes_valid  = out_res_ff.bytes_valid;
   assign rsp_byte_count   = out_res_ff.byte_count;
   assign rsp_toc_valid    = out_res_ff.toc_valid;
   assign rsp_toc_entry    = out_res_ff.toc_entry;

   `ASSERT_NEXT(a_last_restarts, clock, reset, is_byte && req_last_byte, pos_ff == 8'd0)
   `ASSERT_IMPLY(a_toc_needs_xing, clock, reset, rsp_valid && rsp_toc_valid,
                 rsp_header_kind == KIND_XING)
   `ASSERT_IMPLY(a_entry_only_on_read, clock, reset, rsp_valid && rsp_toc_entry != 8'd0,
                 rsp_header_kind == KIND_NONE && !rsp_toc_valid)
   `ASSERT_IMPLY(a_frames_gated, clock, reset, rsp_valid && !rsp_frames_valid,
                 rsp_frame_count == 32'd0)
   `ASSERT_IMPLY(a_toc_write_idle, clock, reset, toc_we, !toc_rdy_ff || new_frame)

endmodule
